// ===== sv/rhht_pkg.sv =====
// Package for the Robin Hood hash table: operation codes, status codes, FNV-1a constants.
`timescale 1ns / 1ps
`default_nettype none
package rhht_pkg;
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // 2^40 + 2^8 + 0xB3
    localparam logic [63:0] FNV_MULT  = 64'd1099511628211;
    localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
    localparam int          HASH_BITS = 48;

    // slot count, a power of two
    localparam int          CAPACITY  = 16;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key;
        logic [63:0] value;
        logic [47:0] hash;
    } t_job;

    function automatic logic [3:0] eff_bytes(input logic [3:0] kb);
        logic [3:0] r;
        begin
            r = kb;
            if (kb == 4'd0) r = 4'd1;
            else if (kb > 4'd8) r = 4'd8;
            return r;
        end
    endfunction

    function automatic logic [63:0] key_mask(input logic [3:0] kb);
        logic [63:0] m;
        begin
            m = '0;
            for (int b = 0; b < 8; b++) begin
                if (4'(b) < eff_bytes(kb)) m[b*8 +: 8] = 8'hFF;
            end
            return m;
        end
    endfunction
endpackage
`default_nettype wire

// ===== sv/rhht_front.sv =====
// Front end: accepts items and hashes the key with FNV-1a, one byte per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rhht_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [3:0]    i_key_bytes,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_func,
    input  wire logic [63:0]   i_key,
    input  wire logic [63:0]   i_value,
    output logic               o_job_valid,
    input  wire logic          i_job_stall,
    output rhht_pkg::t_job     o_job
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HASH = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state       r_state, n_state;
    logic [63:0]  r_h, n_h;
    logic [3:0]   r_i, n_i;
    logic [1:0]   r_func;
    logic [63:0]  r_key, r_value;
    logic [63:0]  w_x;

    assign o_stall     = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    assign o_job.func  = r_func;
    assign o_job.key   = r_key;
    assign o_job.value = r_value;
    assign o_job.hash  = r_h[rhht_pkg::HASH_BITS-1:0];

    assign w_x = r_h ^ {56'd0, r_key[{r_i[2:0], 3'b000} +: 8]};

    always_comb begin
        n_state = r_state;
        n_h = r_h;
        n_i = r_i;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_HASH;
                    n_h = rhht_pkg::FNV_BASIS;
                    n_i = 4'd0;
                end
            end
            S_HASH: begin
                // multiply by the FNV prime as shifts plus a small product
                n_h = (w_x << 40) + (w_x << 8) + (w_x * rhht_pkg::FNV_MULT[7:0]);
                n_i = r_i + 4'd1;
                if (r_i + 4'd1 == rhht_pkg::eff_bytes(i_key_bytes)) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_job_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_h <= n_h;
        r_i <= n_i;
        if (r_state == S_IDLE && i_valid) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end
endmodule
`default_nettype wire

// ===== sv/rhht_queue.sv =====
// Two-entry queue between the hashing front end and the table engine.
`timescale 1ns / 1ps
`default_nettype none
module rhht_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire rhht_pkg::t_job i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output rhht_pkg::t_job     o_data
);
    rhht_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ===== sv/rhht_back.sv =====
// Table engine: Robin Hood probe, insert, lookup, backward-shift remove and clear.
`timescale 1ns / 1ps
`default_nettype none
module rhht_back #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [3:0]    i_key_bytes,
    input  wire logic          i_job_valid,
    output logic               o_job_stall,
    input  wire rhht_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [63:0]        o_value_out,
    output logic [4:0]         o_count
);
    localparam int CAPACITY = rhht_pkg::CAPACITY;
    localparam int IW = $clog2(CAPACITY);
    localparam int DW = IW + 1;
    localparam int CW = IW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROBE = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_RSHR  = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_SWAIT = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;

    logic [DW-1:0]         r_dist [CAPACITY];
    logic [47:0]           m_hash [CAPACITY];
    logic [63:0]           m_key  [CAPACITY];
    logic [VALUE_BITS-1:0] m_val  [CAPACITY];

    logic [47:0]           rd_hash;
    logic [63:0]           rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    logic [1:0]            r_func;
    logic [47:0]           r_h, r_ch;
    logic [63:0]           r_k, r_ck;
    logic [VALUE_BITS-1:0] r_cv;
    logic [DW-1:0]         r_cd;
    logic [IW-1:0]         r_idx, r_prev;
    logic [CW-1:0]         r_step;
    logic [CW-1:0]         r_count;
    logic [1:0]            r_status;
    logic                  r_found;
    logic [63:0]           r_vout;

    logic [63:0]           w_km;
    logic                  w_match, w_own;
    logic [IW-1:0]         w_nx;

    assign w_km    = rhht_pkg::key_mask(i_key_bytes);
    assign w_match = (rd_hash == r_ch) && (((rd_key ^ r_ck) & w_km) == 64'd0);
    assign w_own   = (r_ch == r_h) && (((r_ck ^ r_k) & w_km) == 64'd0);
    assign w_nx    = r_idx + IW'(1);

    assign o_job_stall = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_value_out = r_vout;
    assign o_count     = 5'(r_count);

    always_ff @(posedge i_clk) begin
        rd_hash <= m_hash[r_idx];
        rd_key  <= m_key[r_idx];
        rd_val  <= m_val[r_idx];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            for (int s = 0; s < CAPACITY; s++) r_dist[s] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_func   <= i_job.func;
                    r_h      <= i_job.hash;
                    r_ch     <= i_job.hash;
                    r_k      <= i_job.key;
                    r_ck     <= i_job.key;
                    r_cv     <= i_job.value[VALUE_BITS-1:0];
                    r_cd     <= DW'(1);
                    r_idx    <= i_job.hash[IW-1:0];
                    r_step   <= '0;
                    r_status <= rhht_pkg::ST_DONE;
                    r_found  <= 1'b0;
                    r_vout   <= '0;
                    if (i_job.func == rhht_pkg::FUNC_CLEAR) begin
                        for (int s = 0; s < CAPACITY; s++) r_dist[s] <= '0;
                        r_count <= '0;
                        r_state <= S_OUT;
                    end else if (i_job.func == rhht_pkg::FUNC_INSERT &&
                                 r_count == CW'(CAPACITY)) begin
                        r_status <= rhht_pkg::ST_FULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: r_state <= S_PROBE;
                S_PROBE: begin
                    r_state <= S_WAIT;
                    if (r_step == CW'(CAPACITY)) begin
                        if (r_func == rhht_pkg::FUNC_REMOVE) r_status <= rhht_pkg::ST_NOTFOUND;
                        r_state <= S_OUT;
                    end else if (r_dist[r_idx] == '0) begin
                        if (r_func == rhht_pkg::FUNC_INSERT) begin
                            r_dist[r_idx] <= r_cd;
                            m_hash[r_idx] <= r_ch;
                            m_key[r_idx]  <= r_ck;
                            m_val[r_idx]  <= r_cv;
                            r_count <= r_count + CW'(1);
                        end else if (r_func == rhht_pkg::FUNC_REMOVE) begin
                            r_status <= rhht_pkg::ST_NOTFOUND;
                        end
                        r_state <= S_OUT;
                    end else if (w_match) begin
                        if (r_func == rhht_pkg::FUNC_INSERT) begin
                            m_key[r_idx] <= r_ck;
                            m_val[r_idx] <= r_cv;
                            r_found <= (r_step == '0) || w_own;
                            r_state <= S_OUT;
                        end else if (r_func == rhht_pkg::FUNC_LOOKUP) begin
                            r_found <= 1'b1;
                            r_vout  <= 64'(rd_val);
                            r_state <= S_OUT;
                        end else begin
                            r_found <= 1'b1;
                            r_vout  <= 64'(rd_val);
                            r_dist[r_idx] <= '0;
                            if (r_count != '0) r_count <= r_count - CW'(1);
                            r_prev  <= r_idx;
                            r_idx   <= w_nx;
                            r_step  <= '0;
                            r_state <= S_SWAIT;
                        end
                    end else begin
                        if (r_func == rhht_pkg::FUNC_INSERT && r_dist[r_idx] < r_cd) begin
                            r_dist[r_idx] <= r_cd;
                            m_hash[r_idx] <= r_ch;
                            m_key[r_idx]  <= r_ck;
                            m_val[r_idx]  <= r_cv;
                            r_cd <= r_dist[r_idx] + DW'(1);
                            r_ch <= rd_hash;
                            r_ck <= rd_key;
                            r_cv <= rd_val;
                        end else begin
                            r_cd <= r_cd + DW'(1);
                        end
                        r_idx  <= w_nx;
                        r_step <= r_step + CW'(1);
                    end
                end
                S_SWAIT: r_state <= S_SHIFT;
                S_SHIFT: begin
                    if (r_step == CW'(CAPACITY)) begin
                        r_state <= S_OUT;
                    end else if (r_dist[r_idx] <= DW'(1)) begin
                        r_dist[r_prev] <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_dist[r_prev] <= r_dist[r_idx] - DW'(1);
                        m_hash[r_prev] <= rd_hash;
                        m_key[r_prev]  <= rd_key;
                        m_val[r_prev]  <= rd_val;
                        r_dist[r_idx]  <= '0;
                        r_prev <= r_idx;
                        r_idx  <= w_nx;
                        r_step <= r_step + CW'(1);
                        r_state <= S_RSHR;
                    end
                end
                S_RSHR: r_state <= S_SWAIT;
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/robin_hood_hash_table_core.sv =====
// Top level of the Robin Hood hash table: front hashing stage, queue and table engine.
// Usage:
//   Input channel i_valid / o_stall carries func, key and value; a transfer
//   happens when i_valid is high and o_stall low. Output channel o_valid /
//   i_stall carries status, found, value_out and count, one per input item.
//   The user writes key_bytes via i_cfg_we / i_cfg_data while idle; not enforced.
// Flow:
//   Hashing handles one effective key byte (1 to 8) per cycle. The input
//   channel takes a new item only after the last one is hashed and passed
//   to the queue. The engine turns a clear or a refused insert straight
//   into a result; the other operations probe slot by slot through a
//   registered slot memory read, and a remove then shifts the following
//   slots back. Hashing of the next item overlaps table work through a
//   two-entry queue.
// Reset:
//   Synchronous active-low i_rst_n empties the table, clears the count and
//   sets key_bytes to 8.
// Stalls:
//   A held result stops the engine; the queue then fills and the input
//   channel raises o_stall.
`timescale 1ns / 1ps
`default_nettype none
module robin_hood_hash_table_core #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [63:0] i_key,
    input  wire logic [63:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [63:0]      o_value_out,
    output logic [4:0]       o_count
);
    logic [3:0]     r_key_bytes;
    logic           w_fv, w_fs, w_qv, w_qs;
    rhht_pkg::t_job w_fj, w_qj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= 4'd8;
        end else if (i_cfg_we) begin
            r_key_bytes <= i_cfg_data;
        end
    end

    rhht_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key_bytes(r_key_bytes),
        .i_valid(i_valid), .o_stall(o_stall), .i_func(i_func), .i_key(i_key),
        .i_value(i_value), .o_job_valid(w_fv), .i_job_stall(w_fs), .o_job(w_fj)
    );

    rhht_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_stall(w_fs),
        .i_data(w_fj), .o_valid(w_qv), .i_stall(w_qs), .o_data(w_qj)
    );

    rhht_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key_bytes(r_key_bytes),
        .i_job_valid(w_qv), .o_job_stall(w_qs), .i_job(w_qj),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_found(o_found), .o_value_out(o_value_out), .o_count(o_count)
    );

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_count <= 5'(rhht_pkg::CAPACITY))
        else $error("entry count above capacity");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_count) && $stable(o_status))
        else $error("result changed under stall");
    a_full_nf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == rhht_pkg::ST_FULL |-> !o_found && o_value_out == 64'd0)
        else $error("full insert reported a match");
endmodule
`default_nettype wire

// ===== test/tb_robin_hood_hash_table_core.sv =====
// Testbench for the Robin Hood hash table core: directed and random operations checked against a behavioural table.
`timescale 1ns / 1ps
`default_nettype none
module tb_robin_hood_hash_table_core;
    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [63:0] value_out;
        logic [4:0]  count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_data = 4'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = rhht_pkg::FUNC_LOOKUP;
    logic [63:0] i_key = '0;
    logic [63:0] i_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic        o_found;
    logic [63:0] o_value_out;
    logic [4:0]  o_count;

    robin_hood_hash_table_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_func(i_func), .i_key(i_key),
        .i_value(i_value), .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_found(o_found), .o_value_out(o_value_out), .o_count(o_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // behavioural table
    logic [15:0] tbl_dist [SLOTS];
    logic [47:0] tbl_hash [SLOTS];
    logic [63:0] tbl_key  [SLOTS];
    logic [63:0] tbl_val  [SLOTS];
    int unsigned tbl_count;
    logic [3:0]  key_len;

    t_outcome pending_outcomes[$];
    int  mismatches;
    int  cycles;
    bit  sender_gaps = 1'b1;
    bit  sink_gaps = 1'b1;
    bit  sink_hold = 1'b0;
    int  sink_hold_cycles;
    logic [63:0] used_keys[$];

    function automatic logic [63:0] len_mask();
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
            if (b < ((key_len == 0) ? 1 : (key_len > 8) ? 8 : key_len)) m[b*8 +: 8] = 8'hFF;
        return m;
    endfunction

    function automatic logic [47:0] fnv_hash(logic [63:0] k);
        logic [63:0] h;
        int n;
        h = 64'd14695981039346656037;
        n = (key_len == 0) ? 1 : (key_len > 8) ? 8 : key_len;
        for (int b = 0; b < n; b++) begin
            h = h ^ {56'd0, k[b*8 +: 8]};
            h = h * 64'd1099511628211;
        end
        return h[47:0];
    endfunction

    function automatic int locate(logic [63:0] k, logic [47:0] h);
        int idx;
        idx = h % SLOTS;
        for (int s = 0; s < SLOTS; s++) begin
            if (tbl_dist[idx] == 0) return SLOTS;
            if (tbl_hash[idx] == h && ((tbl_key[idx] ^ k) & len_mask()) == 0) return idx;
            idx = (idx + 1) % SLOTS;
        end
        return SLOTS;
    endfunction

    function automatic t_outcome table_apply(logic [1:0] f, logic [63:0] k, logic [63:0] v);
        t_outcome r;
        logic [47:0] h, ch, th;
        logic [63:0] ck, cv, tk, tv;
        logic [15:0] cd, td;
        int idx, pos, nx;
        r = '0;
        h = fnv_hash(k);
        case (f)
            rhht_pkg::FUNC_INSERT: begin
                if (tbl_count >= SLOTS) begin
                    r.status = rhht_pkg::ST_FULL;
                end else begin
                    cd = 1; ch = h; ck = k; cv = v;
                    idx = h % SLOTS;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (tbl_dist[idx] == 0) begin
                            tbl_dist[idx] = cd; tbl_hash[idx] = ch;
                            tbl_key[idx] = ck; tbl_val[idx] = cv;
                            tbl_count++;
                            break;
                        end
                        if (tbl_hash[idx] == ch && ((tbl_key[idx] ^ ck) & len_mask()) == 0) begin
                            tbl_key[idx] = ck; tbl_val[idx] = cv;
                            if (s == 0 || (ch == h && ((ck ^ k) & len_mask()) == 0))
                                r.found = 1'b1;
                            break;
                        end
                        if (tbl_dist[idx] < cd) begin
                            td = tbl_dist[idx]; th = tbl_hash[idx];
                            tk = tbl_key[idx]; tv = tbl_val[idx];
                            tbl_dist[idx] = cd; tbl_hash[idx] = ch;
                            tbl_key[idx] = ck; tbl_val[idx] = cv;
                            cd = td; ch = th; ck = tk; cv = tv;
                        end
                        idx = (idx + 1) % SLOTS;
                        cd++;
                    end
                end
            end
            rhht_pkg::FUNC_LOOKUP: begin
                pos = locate(k, h);
                if (pos < SLOTS) begin
                    r.found = 1'b1;
                    r.value_out = tbl_val[pos];
                end
            end
            rhht_pkg::FUNC_REMOVE: begin
                pos = locate(k, h);
                if (pos >= SLOTS) begin
                    r.status = rhht_pkg::ST_NOTFOUND;
                end else begin
                    r.found = 1'b1;
                    r.value_out = tbl_val[pos];
                    tbl_dist[pos] = 0;
                    for (int s = 0; s < SLOTS; s++) begin
                        nx = (pos + 1) % SLOTS;
                        if (tbl_dist[nx] <= 1) begin
                            tbl_dist[pos] = 0;
                            break;
                        end
                        tbl_dist[pos] = tbl_dist[nx] - 1;
                        tbl_hash[pos] = tbl_hash[nx];
                        tbl_key[pos] = tbl_key[nx];
                        tbl_val[pos] = tbl_val[nx];
                        tbl_dist[nx] = 0;
                        pos = nx;
                    end
                    if (tbl_count > 0) tbl_count--;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) tbl_dist[i] = 0;
                tbl_count = 0;
            end
        endcase
        r.count = tbl_count[4:0];
        return r;
    endfunction

    task automatic send_op(logic [1:0] f, logic [63:0] k, logic [63:0] v);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_func <= f;
        i_key <= k;
        i_value <= v;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_outcomes.push_back(table_apply(f, k, v));
        if (f == rhht_pkg::FUNC_INSERT) used_keys.push_back(k);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_key_len(logic [3:0] n);
        drain();
        i_cfg_data <= n;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        key_len = n;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return rand64();
    endfunction

    task automatic random_ops(int n);
        logic [1:0] f;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            f = (r < 45) ? rhht_pkg::FUNC_INSERT : (r < 70) ? rhht_pkg::FUNC_LOOKUP
                : (r < 97) ? rhht_pkg::FUNC_REMOVE : rhht_pkg::FUNC_CLEAR;
            send_op(f, pick_key(), rand64());
            if (used_keys.size() > 40) used_keys.delete(0);
        end
    endtask

    task automatic test_directed();
        send_op(rhht_pkg::FUNC_LOOKUP, 64'd0, 64'd0);
        send_op(rhht_pkg::FUNC_REMOVE, 64'd0, 64'd0);
        send_op(rhht_pkg::FUNC_INSERT, 64'd0, 64'd0);
        send_op(rhht_pkg::FUNC_INSERT, '1, '1);
        send_op(rhht_pkg::FUNC_INSERT, '1, 64'h5555_AAAA_5555_AAAA);
        send_op(rhht_pkg::FUNC_LOOKUP, '1, 64'd0);
        send_op(rhht_pkg::FUNC_LOOKUP, 64'd0, '1);
        send_op(rhht_pkg::FUNC_REMOVE, '1, 64'd0);
        send_op(rhht_pkg::FUNC_REMOVE, '1, 64'd0);
        // fill up, refuse, then a lookup of an absent key in a full table, a remove and a clear
        for (int i = 1; i < 17; i++) send_op(rhht_pkg::FUNC_INSERT, 64'(i * 3), rand64());
        send_op(rhht_pkg::FUNC_INSERT, 64'd3, 64'd1);
        send_op(rhht_pkg::FUNC_INSERT, 64'hDEAD, 64'd1);
        send_op(rhht_pkg::FUNC_LOOKUP, 64'hDEAD, 64'd0);
        send_op(rhht_pkg::FUNC_REMOVE, 64'd6, 64'd0);
        send_op(rhht_pkg::FUNC_CLEAR, '1, '1);
    endtask

    task automatic test_key_lengths();
        logic [3:0] lens[6] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd2};
        foreach (lens[j]) begin
            set_key_len(lens[j]);
            send_op(rhht_pkg::FUNC_CLEAR, 64'd0, 64'd0);
            used_keys.delete();
            random_ops(60);
        end
        set_key_len(4'd8);
    endtask

    task automatic test_backpressure();
        sink_hold_cycles = 300;
        sink_hold = 1'b1;
        for (int i = 0; i < 8; i++) send_op(rhht_pkg::FUNC_INSERT, rand64(), rand64());
        drain();
        random_ops(20);
    endtask

    task automatic test_random();
        random_ops(266);
        sender_gaps = 1'b0;
        sink_gaps = 1'b0;
        random_ops(60);
    endtask

    // result side
    always @(negedge i_clk) begin
        if (sink_hold) begin
            i_stall <= 1'b1;
            if (sink_hold_cycles == 0) sink_hold <= 1'b0;
            else sink_hold_cycles <= sink_hold_cycles - 1;
        end else if (sink_gaps && !i_stall && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
        end else if (i_stall && sink_gaps && $urandom_range(0, 3) != 0) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer at cycle %0d", cycles);
            end else begin
                want = pending_outcomes.pop_front();
                if (want.status !== o_status || want.found !== o_found
                        || want.value_out !== o_value_out || want.count !== o_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d fd %0d val %h cnt %0d, got %0d %0d %h %0d",
                                 want.status, want.found, want.value_out, want.count,
                                 o_status, o_found, o_value_out, o_count);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        cycles = 0;
        for (int i = 0; i < SLOTS; i++) tbl_dist[i] = 0;
        tbl_count = 0;
        key_len = 4'd8;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_key_lengths();
        test_random();
        drain();
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("robin_hood_hash_table_core verification clean");
        else
            $display("robin_hood_hash_table_core verification failed");
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("robin_hood_hash_table_core verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== robin_hood_hash_table_core.f =====
sv/rhht_pkg.sv
sv/rhht_front.sv
sv/rhht_queue.sv
sv/rhht_back.sv
sv/robin_hood_hash_table_core.sv
test/tb_robin_hood_hash_table_core.sv
